// ===== sv/spq_pkg.sv =====
// shared types and constants for the severity priority queue
// no dependencies; used by the controller, datapath and top level
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int ID_W   = 16;
   localparam int PRIO_W = 8;
   localparam int OCC_W  = 5;
   localparam int STAT_W = 2;

   // result status codes
   localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

   // request action codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic              capture;
      logic              do_insert;
      logic              do_remove;
      logic              respond;
      logic [STAT_W-1:0] status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_remove;
      logic full;
      logic empty;
   } stat_type;

endpackage

// ===== sv/spq_ctrl.sv =====
// controller state machine for the severity priority queue
// depends on spq_pkg for command and status structs
`timescale 1ns / 1ps

module spq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  spq_pkg::stat_type stat,
   output spq_pkg::cmd_type  cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.status    = spq_pkg::ST_INSERTED;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = start;
         end
         S_EXEC: begin
            cmd.respond = 1'b1;
            if (stat.is_remove) begin
               if (stat.empty) begin
                  cmd.status = spq_pkg::ST_EMPTY;
               end else begin
                  cmd.do_remove = 1'b1;
                  cmd.status    = spq_pkg::ST_REMOVED;
               end
            end else begin
               if (stat.full) begin
                  cmd.status = spq_pkg::ST_FULL;
               end else begin
                  cmd.do_insert = 1'b1;
                  cmd.status    = spq_pkg::ST_INSERTED;
               end
            end
         end
         default: begin
            cmd.capture = 1'b0;
         end
      endcase
   end

endmodule

// ===== sv/spq_datapath.sv =====
// sorted cell chain, request latch and response register
// depends on spq_pkg for widths, codes and command structs
`timescale 1ns / 1ps

module spq_datapath #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  spq_pkg::cmd_type                  cmd,
   output spq_pkg::stat_type                 stat,
   input  logic                              req_action,
   input  logic [spq_pkg::ID_W-1:0]          req_item_id,
   input  logic [spq_pkg::PRIO_W-1:0]        req_priority_req,
   output logic                              rsp_valid,
   output logic [spq_pkg::STAT_W-1:0]        rsp_status,
   output logic [spq_pkg::ID_W-1:0]          rsp_out_id,
   output logic [spq_pkg::PRIO_W-1:0]        rsp_out_priority,
   output logic [spq_pkg::OCC_W-1:0]         rsp_occupancy
);

   localparam int FW = $clog2(DEPTH + 1);

   logic                       action_ff;
   logic [spq_pkg::ID_W-1:0]   id_ff;
   logic [spq_pkg::PRIO_W-1:0] prio_ff;

   logic [spq_pkg::ID_W-1:0]   ids_ff   [DEPTH];
   logic [spq_pkg::ID_W-1:0]   ids_in   [DEPTH];
   logic [spq_pkg::PRIO_W-1:0] pris_ff  [DEPTH];
   logic [spq_pkg::PRIO_W-1:0] pris_in  [DEPTH];
   logic [spq_pkg::ID_W-1:0]   up_ids   [DEPTH];
   logic [spq_pkg::PRIO_W-1:0] up_pris  [DEPTH];
   logic [spq_pkg::ID_W-1:0]   dn_ids   [DEPTH];
   logic [spq_pkg::PRIO_W-1:0] dn_pris  [DEPTH];

   logic [FW-1:0] fill_ff;
   logic [FW-1:0] fill_in;

   logic [DEPTH-1:0] at_or_after;
   logic [DEPTH-1:0] prev_after;

   logic                       rsp_valid_ff;
   logic [spq_pkg::STAT_W-1:0] rsp_status_ff;
   logic [spq_pkg::ID_W-1:0]   rsp_id_ff;
   logic [spq_pkg::PRIO_W-1:0] rsp_prio_ff;
   logic [spq_pkg::OCC_W-1:0]  rsp_occ_ff;

   assign stat.is_remove = (action_ff == spq_pkg::ACT_REMOVE);
   assign stat.full      = (fill_ff == FW'(DEPTH));
   assign stat.empty     = (fill_ff == '0);

   // neighbor views of the chain
   always_comb begin
      for (int k = 0; k < DEPTH - 1; k++) begin
         up_ids[k]  = ids_ff[k+1];
         up_pris[k] = pris_ff[k+1];
      end
      up_ids[DEPTH-1]  = ids_ff[DEPTH-1];
      up_pris[DEPTH-1] = pris_ff[DEPTH-1];
      dn_ids[0]  = id_ff;
      dn_pris[0] = prio_ff;
      for (int k = 1; k < DEPTH; k++) begin
         dn_ids[k]  = ids_ff[k-1];
         dn_pris[k] = pris_ff[k-1];
      end
   end

   // each cell decides whether it sits at or after the insert point
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         at_or_after[k] = (k >= int'(fill_ff)) || (pris_ff[k] < prio_ff);
      end
      prev_after = {at_or_after[DEPTH-2:0], 1'b0};
   end

   always_comb begin
      fill_in = fill_ff;
      for (int k = 0; k < DEPTH; k++) begin
         ids_in[k]  = ids_ff[k];
         pris_in[k] = pris_ff[k];
         if (cmd.do_insert) begin
            if (at_or_after[k] && !prev_after[k]) begin
               ids_in[k]  = id_ff;
               pris_in[k] = prio_ff;
            end else if (at_or_after[k]) begin
               ids_in[k]  = dn_ids[k];
               pris_in[k] = dn_pris[k];
            end
         end else if (cmd.do_remove) begin
            ids_in[k]  = up_ids[k];
            pris_in[k] = up_pris[k];
         end
      end
      if (cmd.do_insert) begin
         fill_in = fill_ff + 1'b1;
      end else if (cmd.do_remove) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         id_ff     <= req_item_id;
         prio_ff   <= req_priority_req;
      end
      ids_ff  <= ids_in;
      pris_ff <= pris_in;
      rsp_status_ff <= cmd.status;
      rsp_id_ff     <= cmd.do_remove ? ids_ff[0] : '0;
      rsp_prio_ff   <= cmd.do_remove ? pris_ff[0] : '0;
      rsp_occ_ff    <= spq_pkg::OCC_W'(fill_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_id       = rsp_id_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_occupancy    = rsp_occ_ff;

endmodule

// ===== sv/severity_priority_queue_core.sv =====
// top level of the severity priority queue: controller plus sorted cell chain
// depends on spq_pkg, spq_ctrl and spq_datapath
//
//   channel   handshake          words
//   request   start / busy       req_action, req_item_id, req_priority_req
//   response  rsp_valid strobe   rsp_status, rsp_out_id, rsp_out_priority, rsp_occupancy
//
// each request word is latched in the idle state, then in the execute state every
// cell of the chain compares against the new priority and shifts in parallel
// the response word shows in the cycle after the execute cycle, for one cycle only
// busy is high during the execute cycle; a new word may start while the
// previous response strobe is still high
// synchronous reset empties the queue; cell contents stay undefined
// the receiver cannot stall, so no output buffering beyond one register
`timescale 1ns / 1ps

module severity_priority_queue_core #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [spq_pkg::ID_W-1:0]      req_item_id,
   input  logic [spq_pkg::PRIO_W-1:0]    req_priority_req,
   output logic                          rsp_valid,
   output logic [spq_pkg::STAT_W-1:0]    rsp_status,
   output logic [spq_pkg::ID_W-1:0]      rsp_out_id,
   output logic [spq_pkg::PRIO_W-1:0]    rsp_out_priority,
   output logic [spq_pkg::OCC_W-1:0]     rsp_occupancy
);

   // command and status between controller and datapath
   spq_pkg::cmd_type  cmd;
   spq_pkg::stat_type stat;

   spq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // cell chain holds entries sorted by descending priority, head in cell 0
   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_action),
      .req_item_id      (req_item_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_priority (rsp_out_priority),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule

// ===== sim/spq_response_checker.sv =====
// response checker for the severity priority queue: tracks accepted request words,
// predicts each response word from its own sorted queue and compares field by field
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_response_checker
   import spq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic              req_action,
   input  logic [ID_W-1:0]   req_item_id,
   input  logic [PRIO_W-1:0] req_priority_req,
   input  logic              rsp_valid,
   input  logic [STAT_W-1:0] rsp_status,
   input  logic [ID_W-1:0]   rsp_out_id,
   input  logic [PRIO_W-1:0] rsp_out_priority,
   input  logic [OCC_W-1:0]  rsp_occupancy,
   output int                mismatches,
   output int                outstanding
);

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic [OCC_W-1:0]  occ;
   } queue_rsp_type;

   queue_rsp_type     due_rsps[$];
   logic [ID_W-1:0]   sorted_ids[DEPTH];
   logic [PRIO_W-1:0] sorted_prios[DEPTH];
   int                stored;

   task automatic report_mismatch(input string msg);
      $display("%0t spq_response_checker: %s", $time, msg);
      mismatches++;
   endtask

   task automatic predict_queue_op(input logic act, input logic [ID_W-1:0] id,
                                   input logic [PRIO_W-1:0] prio,
                                   output queue_rsp_type rsp);
      int pos;
      rsp = '0;
      if (act == ACT_INSERT) begin
         if (stored >= DEPTH) begin
            rsp.status = ST_FULL;
         end else begin
            // new entry goes behind every entry of greater or equal priority
            pos = stored;
            while (pos > 0 && sorted_prios[pos-1] < prio) begin
               sorted_ids[pos]   = sorted_ids[pos-1];
               sorted_prios[pos] = sorted_prios[pos-1];
               pos--;
            end
            sorted_ids[pos]   = id;
            sorted_prios[pos] = prio;
            stored++;
            rsp.status = ST_INSERTED;
         end
      end else begin
         if (stored == 0) begin
            rsp.status = ST_EMPTY;
         end else begin
            rsp.status = ST_REMOVED;
            rsp.id     = sorted_ids[0];
            rsp.prio   = sorted_prios[0];
            for (pos = 0; pos + 1 < stored; pos++) begin
               sorted_ids[pos]   = sorted_ids[pos+1];
               sorted_prios[pos] = sorted_prios[pos+1];
            end
            stored--;
         end
      end
      rsp.occ = stored[OCC_W-1:0];
   endtask

   always @(posedge clock) begin
      queue_rsp_type want;
      if (reset) begin
         stored = 0;
         due_rsps.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (due_rsps.size() == 0) begin
               report_mismatch("response word with nothing due");
            end else begin
               want = due_rsps.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_status, want.status));
               if (rsp_out_id !== want.id)
                  report_mismatch($sformatf("out_id got %h want %h",
                                            rsp_out_id, want.id));
               if (rsp_out_priority !== want.prio)
                  report_mismatch($sformatf("out_priority got %h want %h",
                                            rsp_out_priority, want.prio));
               if (rsp_occupancy !== want.occ)
                  report_mismatch($sformatf("occupancy got %0d want %0d",
                                            rsp_occupancy, want.occ));
            end
         end else if ($isunknown(rsp_valid)) begin
            report_mismatch("rsp_valid unknown");
         end
         if (start === 1'b1 && busy === 1'b0) begin
            predict_queue_op(req_action, req_item_id, req_priority_req, want);
            due_rsps.push_back(want);
         end
      end
      outstanding = due_rsps.size();
   end

endmodule

// ===== sim/tb_top.sv =====
// testbench top for severity_priority_queue_core: makes request words and gives the verdict
// depends on spq_pkg, severity_priority_queue_core and spq_response_checker
`timescale 1ns / 1ps

module tb_top;
   import spq_pkg::*;

   // cycles without any accepted word before the run is called hung
   localparam int STALL_LIMIT = 2000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              req_action = ACT_INSERT;
   logic [ID_W-1:0]   req_item_id = '0;
   logic [PRIO_W-1:0] req_priority_req = '0;
   logic              busy;
   logic              rsp_valid;
   logic [STAT_W-1:0] rsp_status;
   logic [ID_W-1:0]   rsp_out_id;
   logic [PRIO_W-1:0] rsp_out_priority;
   logic [OCC_W-1:0]  rsp_occupancy;

   int mismatches;
   int outstanding;
   int idle_pct;
   int stall_cycles = 0;

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   severity_priority_queue_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_item_id      (req_item_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_priority (rsp_out_priority),
      .rsp_occupancy    (rsp_occupancy)
   );

   // predicts and compares every response word, hands back the failure count
   spq_response_checker check_u (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_item_id      (req_item_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_priority (rsp_out_priority),
      .rsp_occupancy    (rsp_occupancy),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   // watchdog: any accepted request or response word restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // mostly a few low priorities so ties are common, plus full range and extremes
   function automatic logic [PRIO_W-1:0] pick_priority();
      int sel;
      sel = $urandom_range(9);
      if (sel < 5) return PRIO_W'($urandom_range(3));
      if (sel < 8) return PRIO_W'($urandom_range(255));
      if (sel == 8) return '0;
      return '1;
   endfunction

   // drive one request word at the falling edge and hold it until accepted;
   // random sender gaps come first, one falling edge per idle cycle
   task automatic send_word(input logic act, input logic [ID_W-1:0] id,
                            input logic [PRIO_W-1:0] prio);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start            <= 1'b1;
      req_action       <= act;
      req_item_id      <= id;
      req_priority_req <= prio;
      // busy read right after the edge is its value at the edge
      do @(posedge clock); while (busy);
   endtask

   // random part: segments that lean toward filling, toward draining or neither, so the
   // queue keeps running into both the full and the empty case
   task automatic run_random(input int words);
      int sent;
      int seg_len;
      int insert_pct;
      sent = 0;
      while (sent < words) begin
         seg_len = $urandom_range(40, 10);
         case ($urandom_range(2))
            0: insert_pct = 80;
            1: insert_pct = 25;
            default: insert_pct = 50;
         endcase
         repeat (seg_len) begin
            // remove words also carry random id and priority bits
            send_word(($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE,
                      ID_W'($urandom_range(16'hFFFF)), pick_priority());
            sent++;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_pct = 24;
      // directed: remove from empty queue
      send_word(ACT_REMOVE, 16'hFFFF, 8'hFF);
      // field extremes and alternating bit patterns, equal priorities keep arrival order
      send_word(ACT_INSERT, 16'h0000, 8'h00);
      send_word(ACT_INSERT, 16'hFFFF, 8'hFF);
      send_word(ACT_INSERT, 16'hAAAA, 8'h55);
      send_word(ACT_INSERT, 16'h5555, 8'hAA);
      send_word(ACT_INSERT, 16'h1234, 8'h55);
      // fill the rest of the queue
      repeat (11) send_word(ACT_INSERT, ID_W'($urandom_range(16'hFFFF)), pick_priority());
      // insert into a full queue is refused even at top priority
      send_word(ACT_INSERT, 16'hBEEF, 8'hFF);
      repeat (4) send_word(ACT_REMOVE, 16'h0000, 8'h00);

      // sender idle 24 percent, then 62 percent, then never
      run_random(400);
      idle_pct = 62;
      run_random(400);
      idle_pct = 0;
      run_random(400);

      @(negedge clock);
      start <= 1'b0;
      // the watchdog bounds this wait if a response word never shows
      wait (outstanding == 0);
      repeat (4) @(posedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
